// ===== rtl/rgb_to_hsv_convert_defines.svh =====
// assertion macros shared by the rgb to hsv pipeline
`ifndef RGB_TO_HSV_CONVERT_DEFINES_SVH
`define RGB_TO_HSV_CONVERT_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define RHC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition that must never be seen outside reset
`define RHC_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define RHC_ASSERT(lbl, clk, rst, prop, msg)
`define RHC_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// ===== rtl/rhc_pkg.sv =====
`default_nettype none

package rhc_pkg;

  // scaled channel 0..1024
  localparam int CH_W = 11;
  localparam int CH_SHIFT = 10;

  // divider geometry: one quotient bit per stage
  localparam int QW = 11;
  localparam int SAT_DW = 17;
  localparam int HUE_DW = 21;

  localparam int FRONT_STAGES = 3;
  localparam int BACK_STAGES = 2;
  localparam int PIPE_STAGES = FRONT_STAGES + QW + BACK_STAGES;

  localparam int OFF_W = 13;
  localparam int HSUM_W = 13;

  localparam logic [6:0] PERCENT = 7'd100;
  localparam logic [5:0] DEGREES = 6'd60;
  localparam logic [1:0] MIN_SPREAD = 2'd3;

  localparam logic [OFF_W-1:0] OFF_RED = 13'd0;
  localparam logic [OFF_W-1:0] OFF_RED_WRAP = 13'(6 << CH_SHIFT);
  localparam logic [OFF_W-1:0] OFF_GREEN = 13'(2 << CH_SHIFT);
  localparam logic [OFF_W-1:0] OFF_BLUE = 13'(4 << CH_SHIFT);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [8:0] hue;
    logic [6:0] saturation;
    logic [6:0] brightness;
  } hsv_t;

  // per-pixel data that rides alongside the dividers
  typedef struct packed {
    logic [6:0]       brightness;
    logic             gray;
    logic             neg;
    logic [OFF_W-1:0] offset;
  } side_t;

  // (c << 10) / 255 = 4c + floor(4c / 255), the second term is 0..4
  function automatic logic [CH_W-1:0] scale_channel(input logic [7:0] c);
    logic [9:0] c4;
    logic [2:0] adj;
    begin
      c4 = {c, 2'b00};
      adj = 3'(c4 >= 10'd255) + 3'(c4 >= 10'd510) + 3'(c4 >= 10'd765)
          + 3'(c4 >= 10'd1020);
      scale_channel = 11'(c4) + 11'(adj);
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rgb_to_hsv_convert.sv =====
// rgb to hsv pixel converter, fully pipelined
// pipeline from pixel request to hsv request: 3 front, 11 divide, 2 back stages
// throughput: one pixel per cycle while the output is not stalled; the two radix-2 dividers
//   retire one quotient bit per stage, so their 11-bit quotients set the depth
// a stalled output fills bubbles upstream before holding off new pixels
// reset: synchronous, clears all stage valid bits; pipeline empties at once
`default_nettype none
`include "rgb_to_hsv_convert_defines.svh"

module rgb_to_hsv_convert (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pixel_valid,
  output logic                 pixel_ready,
  input  wire rhc_pkg::pixel_t pixel,
  output logic                 hsv_valid,
  input  wire logic            hsv_ready,
  output rhc_pkg::hsv_t        hsv
);

  localparam int N = rhc_pkg::PIPE_STAGES;
  localparam int F = rhc_pkg::FRONT_STAGES;
  localparam int Q = rhc_pkg::QW;
  localparam int CW = rhc_pkg::CH_W;

  logic [N-1:0] v, ld;

  // a stage loads unless it and every stage after it hold a request
  // and the output is stalled
  always_comb begin
    for (int k = 0; k < N; k++) begin
      ld[k] = hsv_ready || !(&(v | ~({N{1'b1}} << k)));
    end
  end

  assign pixel_ready = ld[0];
  assign hsv_valid = v[N-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (ld[k]) begin
          v[k] <= (k == 0) ? pixel_valid : v[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // front end: scale, extremes, divider operands
  logic [rhc_pkg::SAT_DW-1:0] sat_dvd;
  logic [CW-1:0]              sat_dsr, hue_dsr;
  logic [rhc_pkg::HUE_DW-1:0] hue_dvd;
  rhc_pkg::side_t             side_f;

  rhc_front u_front (
    .clk     (clk),
    .ld      (ld[F-1:0]),
    .pixel   (pixel),
    .sat_dvd (sat_dvd),
    .sat_dsr (sat_dsr),
    .hue_dvd (hue_dvd),
    .hue_dsr (hue_dsr),
    .side    (side_f)
  );

  // saturation and hue dividers run side by side
  logic [Q-1:0] sat_q, hue_q;

  rhc_div #(.QW(Q), .DW(rhc_pkg::SAT_DW), .VW(CW)) u_sat_div (
    .clk      (clk),
    .ld       (ld[F+Q-1:F]),
    .dividend (sat_dvd),
    .divisor  (sat_dsr),
    .quotient (sat_q)
  );

  rhc_div #(.QW(Q), .DW(rhc_pkg::HUE_DW), .VW(CW)) u_hue_div (
    .clk      (clk),
    .ld       (ld[F+Q-1:F]),
    .dividend (hue_dvd),
    .divisor  (hue_dsr),
    .quotient (hue_q)
  );

  // side data delay matching the dividers
  rhc_pkg::side_t side_d [Q];

  always_ff @(posedge clk) begin
    for (int j = 0; j < Q; j++) begin
      if (ld[F+j]) begin
        side_d[j] <= (j == 0) ? side_f : side_d[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // back end: hue assembly and output register
  rhc_back u_back (
    .clk   (clk),
    .ld    (ld[N-1:F+Q]),
    .sat_q (sat_q),
    .hue_q (hue_q),
    .side  (side_d[Q-1]),
    .hsv   (hsv)
  );

  // checks
  `RHC_ASSERT(a_fill_count, clk, rst, ((pixel_valid && pixel_ready && !(hsv_valid && hsv_ready)) |=> ($countones(v) == $past($countones(v)) + 1)), "pipeline occupancy did not grow by one")
  `RHC_ASSERT(a_full_when_blocked, clk, rst, (!pixel_ready |-> (&v)), "input held off while a stage is empty")
  `RHC_ASSERT(a_ranges, clk, rst, (hsv_valid |-> (hsv.hue <= 9'd360 && hsv.saturation <= 7'd100 && hsv.brightness <= 7'd100)), "hsv field out of range")
  `RHC_ASSERT_NEVER(a_faint_hue, clk, rst, (hsv_valid && hsv.saturation < 7'd3 && hsv.hue != 9'd0), "faint pixel with nonzero hue")

endmodule

`default_nettype wire

// ===== rtl/rhc_front.sv =====
`default_nettype none

module rhc_front (
  input  wire logic                                  clk,
  input  wire logic [rhc_pkg::FRONT_STAGES-1:0]      ld,
  input  wire rhc_pkg::pixel_t                       pixel,
  output logic [rhc_pkg::SAT_DW-1:0]                 sat_dvd,
  output logic [rhc_pkg::CH_W-1:0]                   sat_dsr,
  output logic [rhc_pkg::HUE_DW-1:0]                 hue_dvd,
  output logic [rhc_pkg::CH_W-1:0]                   hue_dsr,
  output rhc_pkg::side_t                             side
);

  localparam int CW = rhc_pkg::CH_W;

  // stage 1: scaled channels
  logic [CW-1:0] r1, g1, b1;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      r1 <= rhc_pkg::scale_channel(pixel.red);
      g1 <= rhc_pkg::scale_channel(pixel.green);
      b1 <= rhc_pkg::scale_channel(pixel.blue);
    end
  end

  // stage 2: max, min, sextant and channel difference
  logic [CW-1:0] mx2, mn2, absd2;
  logic [CW-1:0] mx2_next, mn2_next, absd2_next;
  logic neg2, neg2_next;
  logic [rhc_pkg::OFF_W-1:0] off2, off2_next;

  always_comb begin
    mx2_next = (r1 > g1) ? ((r1 > b1) ? r1 : b1) : ((g1 > b1) ? g1 : b1);
    mn2_next = (r1 < g1) ? ((r1 < b1) ? r1 : b1) : ((g1 < b1) ? g1 : b1);
    if (mx2_next == r1) begin
      neg2_next = g1 < b1;
      absd2_next = neg2_next ? (b1 - g1) : (g1 - b1);
      off2_next = neg2_next ? rhc_pkg::OFF_RED_WRAP : rhc_pkg::OFF_RED;
    end else if (mx2_next == g1) begin
      neg2_next = b1 < r1;
      absd2_next = neg2_next ? (r1 - b1) : (b1 - r1);
      off2_next = rhc_pkg::OFF_GREEN;
    end else begin
      neg2_next = r1 < g1;
      absd2_next = neg2_next ? (g1 - r1) : (r1 - g1);
      off2_next = rhc_pkg::OFF_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      mx2 <= mx2_next;
      mn2 <= mn2_next;
      absd2 <= absd2_next;
      neg2 <= neg2_next;
      off2 <= off2_next;
    end
  end

  // stage 3: spread, percent products and divider operands
  logic [CW-1:0] delta;
  logic [17:0] sat_prod, val_prod;

  always_comb begin
    delta = mx2 - mn2;
    sat_prod = 18'(delta) * 18'(rhc_pkg::PERCENT);
    val_prod = 18'(mx2) * 18'(rhc_pkg::PERCENT);
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      sat_dvd <= sat_prod[rhc_pkg::SAT_DW-1:0];
      sat_dsr <= mx2;
      hue_dvd <= {absd2, {rhc_pkg::CH_SHIFT{1'b0}}};
      hue_dsr <= delta;
      side.brightness <= val_prod[16:10];
      side.gray <= delta < CW'(rhc_pkg::MIN_SPREAD);
      side.neg <= neg2;
      side.offset <= off2;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rhc_div.sv =====
`default_nettype none

module rhc_div #(
  parameter int QW = 11,
  parameter int DW = 21,
  parameter int VW = 11
) (
  input  wire logic          clk,
  input  wire logic [QW-1:0] ld,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic [QW-1:0]      quotient
);

  // working width holds the dividend and the divisor at its top shift
  localparam int W = (DW > VW + QW) ? DW : VW + QW;

  logic [W-1:0]  rem [QW];
  logic [VW-1:0] dsr [QW];
  logic [QW-1:0] quo [QW];

  // one restoring step per stage, most significant quotient bit first
  for (genvar j = 0; j < QW; j++) begin : g_step
    localparam int B = QW - 1 - j;
    logic [W-1:0]  rem_in, trial;
    logic [VW-1:0] dsr_in;
    logic [QW-1:0] quo_in;
    logic          fits;

    if (j == 0) begin : g_first
      assign rem_in = W'(dividend);
      assign dsr_in = divisor;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem[j-1];
      assign dsr_in = dsr[j-1];
      assign quo_in = quo[j-1];
    end

    assign trial = W'(dsr_in) << B;
    assign fits = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (ld[j]) begin
        rem[j] <= fits ? (rem_in - trial) : rem_in;
        dsr[j] <= dsr_in;
        quo[j] <= quo_in | (QW'(fits) << B);
      end
    end
  end

  assign quotient = quo[QW-1];

endmodule

`default_nettype wire

// ===== rtl/rhc_back.sv =====
`default_nettype none

module rhc_back (
  input  wire logic                              clk,
  input  wire logic [rhc_pkg::BACK_STAGES-1:0]   ld,
  input  wire logic [rhc_pkg::QW-1:0]            sat_q,
  input  wire logic [rhc_pkg::QW-1:0]            hue_q,
  input  wire rhc_pkg::side_t                    side,
  output rhc_pkg::hsv_t                          hsv
);

  localparam int HW = rhc_pkg::HSUM_W;

  // stage 1: sextant offset plus signed quotient, masks
  logic [HW-1:0] hsum, hsum_next;
  logic [6:0]    sat1, bri1;
  logic          zero1;

  always_comb begin
    hsum_next = side.neg ? (side.offset - HW'(hue_q)) : (side.offset + HW'(hue_q));
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      hsum <= hsum_next;
      sat1 <= side.gray ? 7'd0 : sat_q[6:0];
      bri1 <= side.brightness;
      zero1 <= side.gray || (sat_q < rhc_pkg::QW'(rhc_pkg::MIN_SPREAD));
    end
  end

  // stage 2: degrees and output register
  logic [18:0] deg;

  always_comb begin
    deg = 19'(hsum) * 19'(rhc_pkg::DEGREES);
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      hsv.hue <= zero1 ? 9'd0 : deg[18:10];
      hsv.saturation <= sat1;
      hsv.brightness <= bri1;
    end
  end

endmodule

`default_nettype wire
